>>> rtl/mau_pkg.sv
// Shared types, opcodes and constants for the modular arithmetic unit.
`timescale 1ns / 1ps
`default_nettype none
package mau_pkg;

  localparam int unsigned ValueWidthDefault = 31;
  localparam logic [30:0] ModulusReset      = 31'd998244353;

  localparam logic [3:0] OP_REDUCE = 4'd0;
  localparam logic [3:0] OP_ADD    = 4'd1;
  localparam logic [3:0] OP_SUB    = 4'd2;
  localparam logic [3:0] OP_MUL    = 4'd3;
  localparam logic [3:0] OP_DIV    = 4'd4;
  localparam logic [3:0] OP_POW    = 4'd5;
  localparam logic [3:0] OP_INV    = 4'd6;
  localparam logic [3:0] OP_NEG    = 4'd7;
  localparam logic [3:0] OP_INC    = 4'd8;
  localparam logic [3:0] OP_DEC    = 4'd9;

  typedef struct packed {
    logic [3:0]  op;
    logic [30:0] operand_a;
    logic [30:0] operand_b;
    logic [62:0] exponent;
    logic signed [63:0] signed_value;
  } mau_in_t;

  typedef struct packed {
    logic [30:0] result;
    logic        error;
  } mau_out_t;

  // Datapath commands.
  localparam logic [3:0] CMD_NONE    = 4'd0;
  localparam logic [3:0] CMD_LOAD    = 4'd1;  // capture item, precompute simple results
  localparam logic [3:0] CMD_RED64   = 4'd2;  // start 64-bit restoring reduction
  localparam logic [3:0] CMD_MULSET  = 4'd3;  // start modular multiply of mx*my
  localparam logic [3:0] CMD_MSTEP   = 4'd4;  // one bit of the modular multiply
  localparam logic [3:0] CMD_DIVSET  = 4'd5;  // start y / x division
  localparam logic [3:0] CMD_DSTEP   = 4'd6;  // one bit of the division
  localparam logic [3:0] CMD_EUCUPD  = 4'd7;  // Euclid update from quotient
  localparam logic [3:0] CMD_EUCFIN  = 4'd8;  // Euclid finish
  localparam logic [3:0] CMD_PWSQ    = 4'd9;  // pow: take multiply result as new base
  localparam logic [3:0] CMD_PWMUL   = 4'd10; // pow: take multiply result as accumulator
  localparam logic [3:0] CMD_PWSHIFT = 4'd11; // pow: shift exponent
  localparam logic [3:0] CMD_DIVMUL  = 4'd12; // div: multiply a by inverse
  localparam logic [3:0] CMD_TAKEMUL = 4'd13; // result from multiplier
  localparam logic [3:0] CMD_RSTEP   = 4'd14; // one bit of the 64-bit reduction
  localparam logic [3:0] CMD_REDFIN  = 4'd15; // finish reduction

  // Multiplier operand selects.
  localparam logic [1:0] MSEL_AB  = 2'd0;
  localparam logic [1:0] MSEL_RX  = 2'd1;
  localparam logic [1:0] MSEL_XX  = 2'd2;
  localparam logic [1:0] MSEL_AI  = 2'd3;

  typedef struct packed {
    logic [3:0] cmd;
    logic [1:0] msel;
  } mau_cmd_t;

  typedef struct packed {
    logic [3:0] op;
    logic       early;     // result already final (simple ops or errors)
    logic       cnt_done;  // iteration counter reached its end
    logic       x_zero;    // Euclid remainder is zero
    logic       e_zero;    // exponent exhausted
    logic       e_lsb;     // low exponent bit
  } mau_status_t;

endpackage
`default_nettype wire

>>> rtl/modular_arithmetic_unit.sv
// Top level of the modular arithmetic unit: modulus register, controller, datapath.
`timescale 1ns / 1ps
`default_nettype none
//
//  Channel   Direction  Ports                         Handshake
//  input     in         in_valid, in_stall, in_data   transfer when valid & !stall
//  result    out        out_valid, out_stall, out_data transfer when valid & !stall
//  config    in         cfg_we, cfg_data              written when cfg_we is high
//
// One item is worked at a time. Simple operations are computed when the item is loaded;
// mul runs a bit-serial modular multiply, and reduce a one-bit-per-cycle 64-bit
// remainder loop. Pow runs up to 63 rounds of up to two bit-serial multiplies.
// Inverse and div take one divider pass per Euclid round; div then multiplies by the inverse.
// Reset is synchronous and active low; it restores the modulus to its default.
// A finished result waits in an output register, so the next input transfer can be
// taken while it is stalled; that item then holds until the register frees up.
module modular_arithmetic_unit
  import mau_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = ValueWidthDefault
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire mau_in_t                in_data,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output mau_out_t                    out_data,
  input  wire logic                   cfg_we,
  input  wire logic [VALUE_WIDTH-1:0] cfg_data
);

  // Modulus register; the user must write it only while the unit is idle, the block does not enforce this.
  logic [VALUE_WIDTH-1:0] modulus_r;
  mau_cmd_t    cmd;
  mau_status_t status;
  mau_out_t    dp_res;
  logic        done;
  logic        out_busy;
  logic        out_valid_r;
  mau_out_t    out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r <= VALUE_WIDTH'(ModulusReset);
    end else if (cfg_we) begin
      modulus_r <= cfg_data;
    end
  end

  // The output register can take a new result when it is empty or leaving this cycle.
  assign out_busy = out_valid_r && out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (done && !out_busy) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done && !out_busy) begin
      out_data_r <= dp_res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  mau_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .done     (done),
    .out_busy (out_busy),
    .status   (status),
    .cmd      (cmd)
  );

  mau_datapath #(.VALUE_WIDTH(VALUE_WIDTH)) u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .modulus (modulus_r),
    .item    (in_data),
    .cmd     (cmd),
    .status  (status),
    .res     (dp_res)
  );

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.error |-> out_data.result == '0)
    else $error("error result not zero");
  a_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.error |-> out_data.result < 31'(modulus_r))
    else $error("result not below modulus");
  a_data_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_data))
    else $error("result changed under stall");

endmodule
`default_nettype wire

>>> rtl/mau_datapath.sv
// Datapath: operand registers, bit-serial modular multiply, divider and Euclid.
`timescale 1ns / 1ps
`default_nettype none
module mau_datapath
  import mau_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = ValueWidthDefault
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic [VALUE_WIDTH-1:0] modulus,
  input  wire mau_in_t                item,
  input  wire mau_cmd_t               cmd,
  output mau_status_t                 status,
  output mau_out_t                    res
);

  localparam int unsigned W  = VALUE_WIDTH;
  localparam int unsigned CW = 7;  // counts up to 64

  logic [3:0]   op_r;
  logic [W-1:0] m_r, a_r, b_r;
  logic [62:0]  e_r;
  logic [63:0]  sv_r, sv_nxt;
  logic         neg_r;
  logic [W-1:0] acc_r, acc_nxt;   // pow accumulator / simple result
  logic [W-1:0] bx_r, bx_nxt;     // pow base
  logic         err_r, err_nxt, early_r, early_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  // multiplier
  logic [W-1:0] mx_r, mx_nxt, my_r, my_nxt, mp_r, mp_nxt;
  // division / Euclid
  logic [W:0]   x_r, x_nxt, y_r, y_nxt, q_r, q_nxt, rem_r, rem_nxt, dq_r, dq_nxt;
  logic signed [W+1:0] c0_r, c0_nxt, c1_r, c1_nxt;
  logic [W:0]   red_r, red_nxt;  // 64-bit reduction remainder

  logic [W-1:0] mul_a;
  logic [W:0]   dbl, dbl_sub, add_t, add_sub, rsh, rsh_sub;
  logic [W:0]   m_ext;
  logic signed [2*W+3:0] qc_prod;
  logic signed [W+1:0] c_fix;

  assign m_ext = {1'b0, m_r};

  always_comb begin
    mul_a = a_r;
    case (cmd.msel)
      MSEL_AB: mul_a = a_r;
      MSEL_RX: mul_a = acc_r;
      MSEL_XX: mul_a = bx_r;
      MSEL_AI: mul_a = a_r;
      default: mul_a = a_r;
    endcase
  end

  always_comb begin
    logic [W-1:0] lo_a, lo_b, s_a;
    logic [W:0]   s_w;
    logic [W+1:0] s_x;
    lo_a = '0; lo_b = '0; s_a = '0; s_w = '0; s_x = '0;
    sv_nxt = sv_r; acc_nxt = acc_r; bx_nxt = bx_r; err_nxt = err_r;
    early_nxt = early_r; cnt_nxt = cnt_r; mx_nxt = mx_r; my_nxt = my_r;
    mp_nxt = mp_r; x_nxt = x_r; y_nxt = y_r; q_nxt = q_r; rem_nxt = rem_r;
    dq_nxt = dq_r; c0_nxt = c0_r; c1_nxt = c1_r; red_nxt = red_r;
    dbl = '0; dbl_sub = '0; add_t = '0; add_sub = '0; rsh = '0; rsh_sub = '0;
    qc_prod = '0; c_fix = '0;
    case (cmd.cmd)
      CMD_LOAD: begin
        lo_a = item.operand_a[W-1:0];
        lo_b = item.operand_b[W-1:0];
        early_nxt = 1'b1;
        err_nxt = 1'b0;
        acc_nxt = '0;
        sv_nxt = item.signed_value;
        bx_nxt = lo_a;
        cnt_nxt = '0;
        if (modulus == '0 || item.op > OP_DEC) begin
          err_nxt = 1'b1;
        end else if (item.op == OP_REDUCE) begin
          early_nxt = 1'b0;
        end else if (lo_a >= modulus || (item.op <= OP_DIV && lo_b >= modulus)) begin
          err_nxt = 1'b1;
        end else begin
          case (item.op)
            OP_ADD: begin
              s_x = {2'b0, lo_a} + {2'b0, lo_b};
              s_w = s_x[W:0];
              acc_nxt = (s_w >= {1'b0, modulus}) ? W'(s_w - {1'b0, modulus}) : s_w[W-1:0];
            end
            OP_SUB: acc_nxt = (lo_a >= lo_b) ? W'(lo_a - lo_b) : W'(lo_a + modulus - lo_b);
            OP_NEG: acc_nxt = (lo_a != '0) ? W'(modulus - lo_a) : '0;
            OP_INC: acc_nxt = (W'(lo_a + W'(1)) == modulus) ? '0 : W'(lo_a + W'(1));
            OP_DEC: acc_nxt = (lo_a != '0) ? W'(lo_a - W'(1)) : W'(modulus - W'(1));
            OP_POW: begin
              early_nxt = 1'b0;
              acc_nxt = (modulus == W'(1)) ? '0 : W'(1);
            end
            OP_MUL: early_nxt = 1'b0;
            OP_DIV: begin
              early_nxt = 1'b0;
              x_nxt = {1'b0, lo_b};
              y_nxt = {1'b0, modulus};
              c0_nxt = '0; c1_nxt = (W+2)'(1);
            end
            OP_INV: begin
              early_nxt = 1'b0;
              x_nxt = {1'b0, lo_a};
              y_nxt = {1'b0, modulus};
              c0_nxt = '0; c1_nxt = (W+2)'(1);
            end
            default: err_nxt = 1'b1;
          endcase
        end
      end
      CMD_RED64: begin
        if (sv_r[63]) begin
          sv_nxt = ~sv_r + 64'd1;
        end
        red_nxt = '0;
        cnt_nxt = '0;
      end
      CMD_RSTEP: begin
        rsh = {red_r[W-1:0], sv_r[63]};
        rsh_sub = rsh - m_ext;
        red_nxt = (rsh >= m_ext) ? rsh_sub : rsh;
        sv_nxt = {sv_r[62:0], 1'b0};
        cnt_nxt = cnt_r + CW'(1);
      end
      CMD_REDFIN: begin
        if (neg_r && red_r != '0) acc_nxt = W'(m_ext - red_r);
        else acc_nxt = red_r[W-1:0];
        early_nxt = 1'b1;
      end
      CMD_MULSET: begin
        mx_nxt = mul_a;
        case (cmd.msel)
          MSEL_AB: my_nxt = b_r;
          MSEL_RX: my_nxt = bx_r;
          MSEL_XX: my_nxt = bx_r;
          MSEL_AI: my_nxt = acc_r;
          default: my_nxt = b_r;
        endcase
        mp_nxt = '0;
        cnt_nxt = '0;
      end
      CMD_MSTEP: begin
        // Horner: p = 2p + bit * y, each reduced; bits of mx from the top.
        dbl = {mp_r, 1'b0};
        dbl_sub = dbl - m_ext;
        s_a = (dbl >= m_ext) ? dbl_sub[W-1:0] : dbl[W-1:0];
        add_t = {1'b0, s_a} + {1'b0, (mx_r[W-1] ? my_r : '0)};
        add_sub = add_t - m_ext;
        mp_nxt = (add_t >= m_ext) ? add_sub[W-1:0] : add_t[W-1:0];
        mx_nxt = {mx_r[W-2:0], 1'b0};
        cnt_nxt = cnt_r + CW'(1);
      end
      CMD_PWSQ:    bx_nxt = mp_r;
      CMD_PWMUL:   acc_nxt = mp_r;
      CMD_PWSHIFT: cnt_nxt = '0;
      CMD_TAKEMUL: begin
        acc_nxt = mp_r;
        early_nxt = 1'b1;
      end
      CMD_DIVSET: begin
        rem_nxt = '0;
        dq_nxt = y_r;
        q_nxt = '0;
        cnt_nxt = '0;
      end
      CMD_DSTEP: begin
        rsh = {rem_r[W-1:0], dq_r[W]};
        rsh_sub = rsh - x_r;
        if (rsh >= x_r) begin
          rem_nxt = rsh_sub;
          q_nxt = {q_r[W-1:0], 1'b1};
        end else begin
          rem_nxt = rsh;
          q_nxt = {q_r[W-1:0], 1'b0};
        end
        dq_nxt = {dq_r[W-1:0], 1'b0};
        cnt_nxt = cnt_r + CW'(1);
      end
      CMD_EUCUPD: begin
        // y <- x, x <- y mod x; (c0, c1) <- (c1, c0 - q*c1)
        x_nxt = rem_r;
        y_nxt = x_r;
        qc_prod = $signed({1'b0, q_r}) * c1_r;
        c0_nxt = c1_r;
        c1_nxt = c0_r - qc_prod[W+1:0];
      end
      CMD_EUCFIN: begin
        if (y_r != (W+1)'(1)) begin
          err_nxt = 1'b1;
          early_nxt = 1'b1;
          acc_nxt = '0;
        end else begin
          c_fix = c0_r[W+1] ? c0_r + $signed({1'b0, m_ext}) : c0_r;
          s_w = c_fix[W:0];
          acc_nxt = (s_w >= m_ext) ? W'(s_w - m_ext) : s_w[W-1:0];
          early_nxt = (op_r == OP_INV);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.cmd == CMD_LOAD) begin
      op_r  <= item.op;
      m_r   <= modulus;
      a_r   <= item.operand_a[W-1:0];
      b_r   <= item.operand_b[W-1:0];
      e_r   <= item.exponent;
      neg_r <= item.signed_value[63];
    end else if (cmd.cmd == CMD_PWSHIFT) begin
      e_r <= {1'b0, e_r[62:1]};
    end
    sv_r <= sv_nxt; acc_r <= acc_nxt; bx_r <= bx_nxt; mx_r <= mx_nxt;
    my_r <= my_nxt; mp_r <= mp_nxt; x_r <= x_nxt; y_r <= y_nxt; q_r <= q_nxt;
    rem_r <= rem_nxt; dq_r <= dq_nxt; c0_r <= c0_nxt; c1_r <= c1_nxt;
    red_r <= red_nxt; err_r <= err_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      early_r <= 1'b0;
      cnt_r   <= '0;
    end else begin
      early_r <= early_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    status.op = op_r;
    status.early = early_r;
    status.x_zero = (x_r == '0);
    status.e_zero = (e_r == '0);
    status.e_lsb = e_r[0];
    case (cmd.cmd)
      CMD_RSTEP: status.cnt_done = (cnt_r == CW'(63));
      CMD_MSTEP: status.cnt_done = (cnt_r == CW'(W - 1));
      CMD_DSTEP: status.cnt_done = (cnt_r == CW'(W));
      default:   status.cnt_done = 1'b0;
    endcase
  end

  assign res.result = 31'(err_r ? '0 : acc_r);
  assign res.error  = err_r;

endmodule
`default_nettype wire

>>> rtl/mau_ctrl.sv
// Controller state machine sequencing the datapath for each item.
`timescale 1ns / 1ps
`default_nettype none
module mau_ctrl
  import mau_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  output logic             done,
  input  wire logic        out_busy,
  input  wire mau_status_t status,
  output mau_cmd_t         cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DISP   = 4'd1;
  localparam logic [3:0] S_RED    = 4'd2;
  localparam logic [3:0] S_REDFIN = 4'd3;
  localparam logic [3:0] S_MUL    = 4'd4;
  localparam logic [3:0] S_MTAKE  = 4'd5;
  localparam logic [3:0] S_PCHK   = 4'd6;
  localparam logic [3:0] S_PSQ    = 4'd7;
  localparam logic [3:0] S_EUCK   = 4'd8;
  localparam logic [3:0] S_DIV    = 4'd9;
  localparam logic [3:0] S_EUPD   = 4'd10;
  localparam logic [3:0] S_EFIN   = 4'd11;
  localparam logic [3:0] S_POST   = 4'd12;
  localparam logic [3:0] S_OUT    = 4'd13;
  localparam logic [3:0] S_POST2  = 4'd14;

  localparam logic [1:0] K_RES = 2'd0;  // multiply result is the answer
  localparam logic [1:0] K_PMUL = 2'd1;
  localparam logic [1:0] K_PSQ  = 2'd2;

  logic [3:0] state_r, state_nxt;
  logic [1:0] kind_r, kind_nxt;
  logic       accept;

  assign accept   = (state_r == S_IDLE) && in_valid;
  assign in_stall = (state_r != S_IDLE);
  assign done     = (state_r == S_OUT);

  always_comb begin
    state_nxt = state_r;
    kind_nxt = kind_r;
    cmd.cmd = CMD_NONE;
    cmd.msel = MSEL_AB;
    case (state_r)
      S_IDLE: if (accept) begin
        cmd.cmd = CMD_LOAD;
        state_nxt = S_DISP;
      end
      S_DISP: begin
        if (status.early) state_nxt = S_OUT;
        else begin
          case (status.op)
            OP_REDUCE: begin
              cmd.cmd = CMD_RED64;
              state_nxt = S_RED;
            end
            OP_MUL: begin
              cmd.cmd = CMD_MULSET; cmd.msel = MSEL_AB;
              kind_nxt = K_RES; state_nxt = S_MUL;
            end
            OP_POW: state_nxt = S_PCHK;
            default: state_nxt = S_EUCK;
          endcase
        end
      end
      S_RED: begin
        cmd.cmd = CMD_RSTEP;
        if (status.cnt_done) state_nxt = S_REDFIN;
      end
      S_REDFIN: begin
        cmd.cmd = CMD_REDFIN;
        state_nxt = S_OUT;
      end
      S_MUL: begin
        cmd.cmd = CMD_MSTEP;
        if (status.cnt_done) state_nxt = S_MTAKE;
      end
      S_MTAKE: begin
        case (kind_r)
          K_PMUL: begin
            cmd.cmd = CMD_PWMUL; state_nxt = S_PSQ;
          end
          K_PSQ: begin
            cmd.cmd = CMD_PWSQ; state_nxt = S_PCHK;
          end
          default: begin
            cmd.cmd = CMD_TAKEMUL; state_nxt = S_OUT;
          end
        endcase
      end
      S_PCHK: begin
        if (status.e_zero) state_nxt = S_OUT;
        else if (status.e_lsb) begin
          cmd.cmd = CMD_MULSET; cmd.msel = MSEL_RX;
          kind_nxt = K_PMUL; state_nxt = S_MUL;
        end else state_nxt = S_PSQ;
      end
      S_PSQ: begin
        cmd.cmd = CMD_PWSHIFT;
        state_nxt = S_POST;
      end
      S_POST: begin
        cmd.cmd = CMD_MULSET; cmd.msel = MSEL_XX;
        kind_nxt = K_PSQ; state_nxt = S_MUL;
      end
      S_EUCK: begin
        if (status.x_zero) state_nxt = S_EFIN;
        else begin
          cmd.cmd = CMD_DIVSET; state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        cmd.cmd = CMD_DSTEP;
        if (status.cnt_done) state_nxt = S_EUPD;
      end
      S_EUPD: begin
        cmd.cmd = CMD_EUCUPD; state_nxt = S_EUCK;
      end
      S_EFIN: begin
        cmd.cmd = CMD_EUCFIN; state_nxt = S_DISP;
        if (status.op == OP_DIV) begin
          state_nxt = S_POST2;
        end
      end
      S_POST2: begin
        if (status.early) state_nxt = S_OUT;
        else begin
          cmd.cmd = CMD_MULSET; cmd.msel = MSEL_AI;
          kind_nxt = K_RES; state_nxt = S_MUL;
        end
      end
      S_OUT: if (!out_busy) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      kind_r  <= K_RES;
    end else begin
      state_r <= state_nxt;
      kind_r  <= kind_nxt;
    end
  end

  a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done |-> in_stall) else $error("input open while result pending");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    done && out_busy |=> done) else $error("result dropped under stall");
  a_accept_leads: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == S_DISP) else $error("accept did not start dispatch");

endmodule
`default_nettype wire

>>> tb/modular_arithmetic_unit_tb.sv
// Self-checking testbench for the modular arithmetic unit: random and directed items.
`timescale 1ns / 1ps
`default_nettype none
module modular_arithmetic_unit_tb;
  import mau_pkg::*;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  mau_in_t  in_data;
  logic     out_valid;
  logic     out_stall;
  mau_out_t out_data;
  logic     cfg_we;
  logic [30:0] cfg_data;

  modular_arithmetic_unit DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  // Items waiting to be driven, and the residues the block owes us, oldest first.
  mau_in_t  pending_items[$];
  mau_out_t owed_residues[$];

  // The predictor keeps its own copy of the modulus, updated when we write it.
  logic [30:0] model_modulus;

  int  send_idle_pct;
  int  recv_idle_pct;
  int  recv_hold_cycles;
  bit  failed;
  int  quiet_cycles;
  int  accepted_count;

  localparam int QuietLimit = 40000;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Extended Euclid on 64-bit signed coefficients; returns 0 when no inverse exists.
  function automatic bit find_inverse(input longint unsigned a, input longint unsigned m,
                                      output longint unsigned inv);
    longint c0, c1, t;
    longint unsigned x, y, q, tmp;
    c0 = 0;
    c1 = 1;
    x = a;
    y = m;
    while (x != 0) begin
      q = y / x;
      y = y - q * x;
      tmp = x; x = y; y = tmp;
      c0 = c0 - longint'(q) * c1;
      t = c0; c0 = c1; c1 = t;
    end
    if (y != 1) begin
      inv = 0;
      return 1'b0;
    end
    inv = (c0 < 0) ? longint'(c0 + longint'(m)) : c0;
    inv = inv % m;
    return 1'b1;
  endfunction

  function automatic longint unsigned power_mod(input longint unsigned base,
                                                input longint unsigned p,
                                                input longint unsigned m);
    longint unsigned r, x;
    r = 1 % m;
    x = base;
    while (p != 0) begin
      if (p[0]) r = (r * x) % m;
      p = p >> 1;
      x = (x * x) % m;
    end
    return r;
  endfunction

  // Computes the residue and error flag that one item must produce.
  function automatic mau_out_t residue_of(input mau_in_t it);
    longint unsigned m, a, b, sv, mag, t, r, inv;
    bit err;
    mau_out_t res;
    m = 64'(model_modulus);
    a = 64'(it.operand_a);
    b = 64'(it.operand_b);
    sv = it.signed_value;
    r = 0;
    err = 1'b0;
    if (m == 0 || it.op > OP_DEC) begin
      err = 1'b1;
    end else if (it.op == OP_REDUCE) begin
      if (sv[63] == 1'b0) begin
        r = sv % m;
      end else begin
        mag = (~sv) + 1;
        t = mag % m;
        r = (t != 0) ? m - t : 0;
      end
    end else if (a >= m || (it.op <= OP_DIV && b >= m)) begin
      err = 1'b1;
    end else begin
      case (it.op)
        OP_ADD: r = (a + b) % m;
        OP_SUB: r = (a >= b) ? a - b : a + m - b;
        OP_MUL: r = (a * b) % m;
        OP_DIV: begin
          if (find_inverse(b, m, inv)) r = (a * inv) % m;
          else err = 1'b1;
        end
        OP_POW: r = power_mod(a, {1'b0, it.exponent}, m);
        OP_INV: begin
          if (find_inverse(a, m, inv)) r = inv;
          else err = 1'b1;
        end
        OP_NEG: r = (a != 0) ? m - a : 0;
        OP_INC: r = (a + 1 == m) ? 0 : a + 1;
        default: r = (a != 0) ? a - 1 : m - 1;
      endcase
    end
    if (err) r = 0;
    res.result = r[30:0];
    res.error = err;
    return res;
  endfunction

  // Picks an operand that is usually a valid residue, sometimes at or above the modulus.
  function automatic logic [30:0] pick_operand();
    int unsigned sel;
    longint unsigned m;
    m = 64'(model_modulus);
    sel = $urandom_range(0, 19);
    if (sel == 0) return 31'($urandom());
    if (sel == 1) return 31'd0;
    if (sel == 2 && m > 0) return 31'(m - 1);
    if (sel == 3) return 31'(m);
    if (m == 0) return 31'($urandom());
    return 31'($urandom() % m);
  endfunction

  function automatic mau_in_t random_item();
    mau_in_t it;
    it.op = ($urandom_range(0, 49) == 0) ? 4'($urandom_range(10, 15))
                                         : 4'($urandom_range(0, 9));
    it.operand_a = pick_operand();
    it.operand_b = pick_operand();
    it.exponent = 63'({$urandom(), $urandom()});
    if ($urandom_range(0, 3) == 0) it.exponent = 63'($urandom_range(0, 20));
    it.signed_value = {$urandom(), $urandom()};
    if ($urandom_range(0, 7) == 0) it.signed_value = longint'($urandom_range(0, 9)) - 5;
    return it;
  endfunction

  function automatic mau_in_t make_item(input logic [3:0] op, input longint unsigned a,
                                        input longint unsigned b, input longint unsigned e,
                                        input longint unsigned sv);
    mau_in_t it;
    it.op = op;
    it.operand_a = 31'(a);
    it.operand_b = 31'(b);
    it.exponent = 63'(e);
    it.signed_value = sv;
    return it;
  endfunction

  // Waits until the driver has emptied its queue and every result has come back.
  task automatic drain();
    while (pending_items.size() != 0 || owed_residues.size() != 0 || in_valid)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Modulus writes happen only while the block is idle.
  task automatic write_modulus(input logic [30:0] value);
    drain();
    cfg_we <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    model_modulus = value;
    @(posedge clk);
  endtask

  task automatic queue_random(input int count);
    repeat (count) pending_items.push_back(random_item());
  endtask

  // Driver: presents the head of the queue and holds it until a transfer happens.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        owed_residues.push_back(residue_of(in_data));
        void'(pending_items.pop_front());
      end
      if (in_valid && in_stall) begin
        // A stalled item stays on the bus unchanged.
      end else if (pending_items.size() > 0 &&
                   $urandom_range(0, 99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_data <= pending_items[0];
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: checks each result transfer against the oldest owed residue.
  always @(posedge clk) begin
    mau_out_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        accepted_count <= accepted_count + 1;
        if (owed_residues.size() == 0) begin
          $error("unexpected result transfer: result=%0d error=%0b",
                 out_data.result, out_data.error);
          failed = 1'b1;
        end else begin
          want = owed_residues.pop_front();
          if (out_data.result !== want.result) begin
            $error("result mismatch: expected %0d, actual %0d", want.result, out_data.result);
            failed = 1'b1;
          end
          if (out_data.error !== want.error) begin
            $error("error mismatch: expected %0b, actual %0b", want.error, out_data.error);
            failed = 1'b1;
          end
        end
      end
      // The receiver either holds off for a counted stretch or stalls at random.
      if (recv_hold_cycles > 0) begin
        recv_hold_cycles <= recv_hold_cycles - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
    end
  end

  // Watchdog: ends the run when nothing transfers for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QuietLimit) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Main sequence.
  initial begin
    failed = 1'b0;
    accepted_count = 0;
    send_idle_pct = 9;
    recv_idle_pct = 65;
    recv_hold_cycles = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_data = '0;
    model_modulus = ModulusReset;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part at the reset modulus: every operation, field extremes, error cases.
    pending_items.push_back(make_item(OP_REDUCE, 0, 0, 0, 64'h8000_0000_0000_0000));
    pending_items.push_back(make_item(OP_REDUCE, 0, 0, 0, 64'h7FFF_FFFF_FFFF_FFFF));
    pending_items.push_back(make_item(OP_REDUCE, 0, 0, 0, -64'sd1));
    pending_items.push_back(make_item(OP_ADD, 998244352, 998244352, 0, 0));
    pending_items.push_back(make_item(OP_SUB, 0, 998244352, 0, 0));
    pending_items.push_back(make_item(OP_MUL, 998244352, 998244352, 0, 0));
    pending_items.push_back(make_item(OP_DIV, 5, 0, 0, 0));
    pending_items.push_back(make_item(OP_DIV, 5, 3, 0, 0));
    pending_items.push_back(make_item(OP_POW, 3, 0, 0, 0));
    pending_items.push_back(make_item(OP_POW, 998244352, 0, 63'h7FFF_FFFF_FFFF_FFFF, 0));
    pending_items.push_back(make_item(OP_INV, 0, 0, 0, 0));
    pending_items.push_back(make_item(OP_INV, 2, 0, 0, 0));
    pending_items.push_back(make_item(OP_NEG, 0, 0, 0, 0));
    pending_items.push_back(make_item(OP_NEG, 1, 0, 0, 0));
    pending_items.push_back(make_item(OP_INC, 998244352, 0, 0, 0));
    pending_items.push_back(make_item(OP_DEC, 0, 0, 0, 0));
    pending_items.push_back(make_item(OP_ADD, 31'h7FFF_FFFF, 0, 0, 0));
    pending_items.push_back(make_item(OP_MUL, 0, 998244353, 0, 0));
    pending_items.push_back(make_item(4'd15, 0, 0, 0, 0));
    pending_items.push_back(make_item(4'd10, 1, 1, 0, 0));
    drain();

    // Modulus one, then zero, then a composite modulus where inverses often do not exist.
    write_modulus(31'd1);
    pending_items.push_back(make_item(OP_INV, 0, 0, 0, 0));
    pending_items.push_back(make_item(OP_POW, 0, 0, 0, 0));
    queue_random(60);
    write_modulus(31'd0);
    queue_random(30);
    write_modulus(31'd360);
    queue_random(250);

    // Long receiver hold-off while the sender keeps offering items.
    drain();
    recv_hold_cycles = 3000;
    queue_random(40);
    write_modulus(31'h7FFF_FFFF);
    queue_random(350);
    write_modulus(31'd2);
    queue_random(100);

    // Swap the idle rates.
    drain();
    send_idle_pct = 65;
    recv_idle_pct = 9;
    write_modulus(31'd65536);
    queue_random(300);
    write_modulus(31'd1000000007);
    queue_random(300);

    // No idling on either side.
    drain();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_modulus(31'd97);
    queue_random(250);
    write_modulus(ModulusReset);
    queue_random(270);

    drain();
    repeat (300) @(posedge clk);
    if (!failed && owed_residues.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
`default_nettype wire

>>> files.f
rtl/mau_pkg.sv
rtl/mau_datapath.sv
rtl/mau_ctrl.sv
rtl/modular_arithmetic_unit.sv
tb/modular_arithmetic_unit_tb.sv
